// ===== design/rsis_pkg.sv =====
// ----------------------------------------------------------------------------
// rsis_pkg
// Shared types and codes for the rejection-sampled index shuffle core.
// ----------------------------------------------------------------------------
`default_nettype none

package rsis_pkg;

  // Operation codes carried in the input tuser field
  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_PASS = 2'd1,
    OP_BYTE = 2'd2,
    OP_READ = 2'd3
  } op_e;

  // Request from the sequencer to the permutation table
  typedef struct packed {
    logic       clear;
    logic       rd_en;
    logic [7:0] rd_addr;
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
  } tbl_req_t;

endpackage

`default_nettype wire

// ===== design/rejection_sampled_index_shuffle_core.sv =====
// ----------------------------------------------------------------------------
// rejection_sampled_index_shuffle_core
// Fisher-Yates shuffle of a permutation table driven by rejection-sampled
// entropy bytes.
// ----------------------------------------------------------------------------
// One word is taken at a time, and s_axis_tready stays low until its result
// word has been loaded into the output register. Init and new-pass words go
// straight to the emit state, and a read waits for the table's registered
// read. An entropy byte runs through the bit-serial remainder unit (load, 8
// quotient bits, done) that reduces the byte modulo the remaining count; an
// accepted byte is then swapped in, reading and writing the two table entries
// one after the other through the table's one read and one write port, and a
// rejected byte goes straight to the result word, as does a byte after the
// pass is complete. Each word waits in the emit state while the output
// register stays full. The table needs no clearing pass: per-entry valid bits
// make unwritten entries read as identity.
// ----------------------------------------------------------------------------
`default_nettype none

module rejection_sampled_index_shuffle_core import rsis_pkg::*; #(
  parameter int INDEX_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] entropy_byte, [15:8] read_index
  input  logic [1:0]  s_axis_tuser,  // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] entry_value, [8] sample_accepted, [9] pass_complete,
  // [17:10] next_position, [23:18] zero
  output logic [23:0] m_axis_tdata
);

  localparam logic [8:0] COUNT = 9'(INDEX_COUNT);
  localparam logic [7:0] LAST  = 8'(INDEX_COUNT - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIVGO, S_DIV, S_RDA, S_RDB, S_WRA, S_WRB, S_READ, S_READW, S_EMIT
  } state_e;

  state_e     state_q;
  logic [7:0] dest_q;
  logic       done_q;
  logic [7:0] sample_q;
  logic [7:0] idx_q;
  logic [8:0] remain_q;
  logic [7:0] swap_q;
  logic [7:0] hold_q;
  logic [7:0] value_q;
  logic       acc_q;
  logic       out_valid_q;
  logic [23:0] out_data_q;

  logic       in_acc;
  op_e        op;
  logic [7:0] in_byte;
  logic [7:0] in_idx;
  tbl_req_t   tbl_req;
  logic [7:0] tbl_data;
  logic       div_done;
  logic [7:0] div_rem;
  logic [9:0] room;

  assign op      = op_e'(s_axis_tuser);
  assign in_byte = s_axis_tdata[7:0];
  assign in_idx  = s_axis_tdata[15:8];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  // (quotient + 1) * remaining must not pass 256 for an unbiased sample
  assign room = {2'b00, sample_q} - {2'b00, div_rem} + {1'b0, remain_q};

  rsis_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DIVGO),
    .dividend_i (sample_q),
    .divisor_i  (remain_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  rsis_table #(.INDEX_COUNT(INDEX_COUNT)) u_tbl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (tbl_req),
    .rd_data_o (tbl_data)
  );

  always_comb begin
    tbl_req = '0;
    unique case (state_q)
      S_IDLE: tbl_req.clear = in_acc && (op == OP_INIT);
      S_RDA: begin
        tbl_req.rd_en   = 1'b1;
        tbl_req.rd_addr = dest_q;
      end
      S_RDB: begin
        tbl_req.rd_en   = 1'b1;
        tbl_req.rd_addr = swap_q;
      end
      S_WRA: begin
        tbl_req.wr_en   = 1'b1;
        tbl_req.wr_addr = dest_q;
        tbl_req.wr_data = tbl_data;
      end
      S_WRB: begin
        tbl_req.wr_en   = 1'b1;
        tbl_req.wr_addr = swap_q;
        tbl_req.wr_data = hold_q;
      end
      S_READ: begin
        tbl_req.rd_en   = 1'b1;
        tbl_req.rd_addr = idx_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dest_q      <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= 1'b0;
      value_q     <= '0;
      sample_q    <= '0;
      idx_q       <= '0;
      remain_q    <= '0;
      swap_q      <= '0;
      hold_q      <= '0;
      out_data_q  <= '0;
    end else begin
      // the emit state reloads the output register itself when it is taken
      if (m_axis_tready && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            acc_q    <= 1'b0;
            value_q  <= '0;
            sample_q <= in_byte;
            idx_q    <= in_idx;
            remain_q <= COUNT - {1'b0, dest_q};
            unique case (op) inside
              OP_INIT, OP_PASS: begin
                dest_q  <= '0;
                done_q  <= 1'b0;
                state_q <= S_EMIT;
              end
              OP_BYTE: begin
                if (done_q || (dest_q >= LAST)) begin
                  done_q  <= 1'b1;
                  state_q <= S_EMIT;
                end else begin
                  state_q <= S_DIVGO;
                end
              end
              OP_READ: begin
                state_q <= ({1'b0, in_idx} >= COUNT) ? S_EMIT : S_READ;
              end
              default: state_q <= S_EMIT;
            endcase
          end
        end
        S_DIVGO: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            if (room > 10'd256) begin
              state_q <= S_EMIT;  // drop the biased sample
            end else begin
              swap_q  <= dest_q + div_rem;
              state_q <= S_RDA;
            end
          end
        end
        S_RDA: state_q <= S_RDB;
        S_RDB: begin
          hold_q  <= tbl_data;
          state_q <= S_WRA;
        end
        S_WRA: state_q <= S_WRB;
        S_WRB: begin
          dest_q  <= dest_q + 8'd1;
          done_q  <= ((dest_q + 8'd1) >= LAST);
          acc_q   <= 1'b1;
          state_q <= S_EMIT;
        end
        S_READ: state_q <= S_READW;
        S_READW: begin
          value_q <= tbl_data;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the output register is free
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {6'd0, dest_q, done_q, acc_q, value_q};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== design/rsis_divider.sv =====
// ----------------------------------------------------------------------------
// rsis_divider
// Restoring radix-2 remainder unit: 8-bit dividend by 9-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rsis_divider (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] dividend_i,
  input  logic [8:0] divisor_i,
  output logic       done_o,
  output logic [7:0] rem_o
);

  logic       busy_q, busy_d;
  logic       done_q, done_d;
  logic [2:0] cnt_q, cnt_d;
  logic [7:0] rem_q, rem_d;
  logic [7:0] quo_q, quo_d;
  logic [8:0] div_q, div_d;
  logic [8:0] trial;
  logic       ge;

  assign trial = {rem_q, quo_q[7]};
  assign ge    = (trial >= div_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      rem_d = ge ? 8'(trial - div_q) : trial[7:0];
      quo_d = {quo_q[6:0], ge};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== design/rsis_table.sv =====
// ----------------------------------------------------------------------------
// rsis_table
// Permutation table: one write and one registered read per cycle. Entries
// not written since reset or clear read back as their own index.
// ----------------------------------------------------------------------------
`default_nettype none

module rsis_table import rsis_pkg::*; #(
  parameter int INDEX_COUNT = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tbl_req_t   req_i,
  output logic [7:0] rd_data_o
);

  localparam int IDX_W = $clog2(INDEX_COUNT);

  logic [7:0]           mem [INDEX_COUNT];
  logic [INDEX_COUNT-1:0] valid_q;
  logic [7:0]           rd_data_q;
  logic [7:0]           rd_addr_q;
  logic                 rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr[IDX_W-1:0]] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr[IDX_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr[IDX_W-1:0]] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr[IDX_W-1:0]];
      rd_addr_q <= req_i.rd_addr;
    end
  end

  // unwritten entries hold the identity
  assign rd_data_o = rd_valid_q ? rd_data_q : rd_addr_q;

endmodule

`default_nettype wire

// ===== design/rsis_checker.sv =====
// ----------------------------------------------------------------------------
// rsis_checker
// Port-level checks for the shuffle core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rsis_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [23:0] m_axis_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // one word in flight: no second word right after an accepted one
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a word is in progress");

  // a swap never reports an entry value and always advances the position
  a_swap_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |->
      (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[17:10] != 8'd0))
    else $error("accepted sample with bad fields");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:18] == 6'd0)
    else $error("nonzero padding in result word");

endmodule

bind rejection_sampled_index_shuffle_core rsis_checker u_rsis_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
